// ----- rtl/sal_pkg.sv -----
// sorted address list package: operation and status codes, cell control struct
// and default sizes shared by the cell, encoder and top level
// no dependencies
package sal_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam int unsigned ADDR_IN_W      = 32;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned ST_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // control broadcast to every cell
  typedef struct packed {
    logic ins;  // operation is an insert
    logic del;  // operation is a delete
    logic wr;   // table changes on this word
  } ctrl_t;

endpackage

// ----- rtl/sal_cell.sv -----
// one cell of the sorted chain: holds one address, compares it against the key
// and shifts toward its neighbor on insert or delete; uses sal_pkg
module sal_cell #(
  parameter int unsigned ADDR_WIDTH = sal_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  sal_pkg::ctrl_t        ctrl_i,
  input  logic                  ins_i,
  input  logic [ADDR_WIDTH-1:0] key_i,
  input  logic                  valid_i,
  input  logic [ADDR_WIDTH-1:0] left_entry_i,
  input  logic                  left_take_i,
  input  logic                  left_eq_i,
  input  logic [ADDR_WIDTH-1:0] right_entry_i,
  output logic [ADDR_WIDTH-1:0] entry_o,
  output logic                  take_o,
  output logic                  eq_o,
  output logic                  mark_o
);
  import sal_pkg::*;

  logic [ADDR_WIDTH-1:0] entry_q, entry_d;
  logic                  gt, eq, take;

  assign gt   = valid_i && (entry_q > key_i);
  assign eq   = valid_i && (entry_q == key_i);
  // an empty cell accepts the key or the shifted word on insert
  assign take = gt || !valid_i;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr && ctrl_i.ins) begin
      if (left_take_i) begin
        entry_d = left_entry_i;
      end else if (take) begin
        entry_d = key_i;
      end
    end else if (ctrl_i.wr && ctrl_i.del && (gt || eq)) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign take_o  = take;
  assign eq_o    = eq;
  // boundary of the thermometer: insertion point or first equal entry
  // ins_i is kept apart from ctrl_i so the mark does not loop back through ctrl.wr
  assign mark_o  = ins_i ? (take && !left_take_i) : (eq && !left_eq_i);

endmodule

// ----- rtl/sal_onehot_enc.sv -----
// one-hot to index encoder for the cell boundary marks
// depends on sal_pkg for the default size
module sal_onehot_enc #(
  parameter int unsigned N = sal_pkg::DEPTH_DEF
) (
  input  logic [N-1:0]         onehot_i,
  output logic [$clog2(N)-1:0] index_o,
  output logic                 any_o
);
  localparam int unsigned IdxW = $clog2(N);

  always_comb begin
    index_o = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot_i[i]) begin
        index_o = index_o | IdxW'(i);
      end
    end
  end

  assign any_o = |onehot_i;

endmodule

// ----- rtl/sorted_address_list.sv -----
// sorted address list: a chain of DEPTH cells keeping addresses in ascending order
// each accepted word's result is registered; cells compare in parallel, shift by one
// throughput: one word per cycle while the output is not stalled
// reset: clears the entry count and output valid; cell contents are left as they are
// depends on sal_pkg, sal_cell, sal_onehot_enc
module sorted_address_list #(
  parameter int unsigned DEPTH      = sal_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_WIDTH = sal_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation[1:0], address[33:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], position, entry_count, zero pad
  output logic [((sal_pkg::ST_W + $clog2(DEPTH) + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
               m_axis_tdata
);
  import sal_pkg::*;

  localparam int unsigned PosW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned OutW = ((ST_W + PosW + CntW + 7) / 8) * 8;

  logic                  s_fire;
  op_e                   op;
  logic                  op_ins;
  logic [ADDR_IN_W-1:0]  addr_in;
  logic [ADDR_WIDTH-1:0] key;
  ctrl_t                 ctrl;

  logic [CntW-1:0] count_q, count_d;
  logic            full;

  logic [ADDR_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]      valid, take, eq, mark;

  logic [PosW-1:0] hit_pos;
  logic            hit;

  status_e         status;
  logic [PosW-1:0] pos;

  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tdata[OP_W-1:0]);
  assign op_ins        = (op == OP_INSERT);
  assign addr_in       = s_axis_tdata[OP_W +: ADDR_IN_W];

  generate
    if (ADDR_WIDTH > ADDR_IN_W) begin : g_key_wide
      assign key = {{(ADDR_WIDTH - ADDR_IN_W){1'b0}}, addr_in};
    end else if (ADDR_WIDTH == ADDR_IN_W) begin : g_key_eq
      assign key = addr_in;
    end else begin : g_key_narrow
      assign key = addr_in[ADDR_WIDTH-1:0];
    end
  endgenerate

  assign full = (count_q == CntW'(DEPTH));

  always_comb begin
    ctrl.ins = op_ins;
    ctrl.del = (op == OP_DELETE);
    ctrl.wr  = s_fire && ((ctrl.ins && !full) || (ctrl.del && hit));
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ADDR_WIDTH-1:0] left_entry, right_entry;
    logic                  left_take, left_eq;

    assign valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign left_entry = key;
      assign left_take  = 1'b0;
      assign left_eq    = 1'b0;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_take  = take[i-1];
      assign left_eq    = eq[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    sal_cell #(
      .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .ins_i         (op_ins),
      .key_i         (key),
      .valid_i       (valid[i]),
      .left_entry_i  (left_entry),
      .left_take_i   (left_take),
      .left_eq_i     (left_eq),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .take_o        (take[i]),
      .eq_o          (eq[i]),
      .mark_o        (mark[i])
    );
  end

  sal_onehot_enc #(
    .N (DEPTH)
  ) u_enc (
    .onehot_i (mark),
    .index_o  (hit_pos),
    .any_o    (hit)
  );

  always_comb begin
    status = ST_MISSING;
    unique case (op)
      OP_INSERT: status = full ? ST_FULL : ST_OK;
      OP_SEARCH,
      OP_DELETE: status = hit ? ST_OK : ST_MISSING;
      default:   status = ST_MISSING;
    endcase
  end

  assign pos = (status == ST_OK) ? hit_pos : '0;

  always_comb begin
    count_d = count_q;
    if (ctrl.wr) begin
      count_d = ctrl.ins ? count_q + CntW'(1) : count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= OutW'({count_d, pos, status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && op == OP_INSERT && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("accepted insert did not grow the table");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[ST_W-1:0] != ST_OK) |->
      (m_axis_tdata[ST_W +: PosW] == '0))
    else $error("position nonzero on a failed operation");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[ST_W-1:0] == ST_FULL) |->
      (m_axis_tdata[ST_W + PosW +: CntW] == CntW'(DEPTH)))
    else $error("full status with a table that is not full");
`endif

endmodule

// ----- tb/sorted_address_list_test.sv -----
// testbench for sorted_address_list: directed and random insert, search and delete words
// checked against a shadow copy of the sorted table kept in the testbench
// depends on sal_pkg and the sorted_address_list rtl
`timescale 1ns / 1ps

module sorted_address_list_test;
  import sal_pkg::*;

  localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
  localparam int unsigned POS_W       = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int unsigned RES_W       = ((ST_W + POS_W + CNT_W + 7) / 8) * 8;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 28;
  localparam int unsigned PHASE_WORDS = 50;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } list_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [RES_W-1:0] m_axis_tdata;

  // shadow of the sorted table
  logic [31:0]  held_addr [LIST_DEPTH];
  int unsigned  held_count;
  list_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent [4];
  int unsigned full_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned misses_seen = 0;
  bit          no_idle;
  logic [31:0] addr_pool [6];

  sorted_address_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (no_idle)
      return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 13);
  endfunction

  // applies one operation to the shadow table and returns the answer it gives
  function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                 input logic [31:0] addr);
    list_result_t res;
    int unsigned  slot;
    int unsigned  i;
    int           hit;
    res.status = ST_MISSING;
    res.position = '0;
    hit = -1;
    for (i = 0; i < held_count; i++)
      if (hit < 0 && held_addr[i] == addr)
        hit = i;
    case (op)
      OP_INSERT: begin
        if (held_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < held_count && held_addr[slot] <= addr)
            slot++;
          for (i = held_count; i > slot; i--)
            held_addr[i] = held_addr[i-1];
          held_addr[slot] = addr;
          held_count++;
          res.status = ST_OK;
          res.position = slot[POS_W-1:0];
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          res.status = ST_OK;
          res.position = hit[POS_W-1:0];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < held_count; i++)
            held_addr[i] = held_addr[i+1];
          held_count--;
          res.status = ST_OK;
          res.position = hit[POS_W-1:0];
        end
      end
      default: ;
    endcase
    res.entry_count = held_count[CNT_W-1:0];
    return res;
  endfunction

  // drives one word, returns at the falling edge after it was taken
  task automatic send_word(input logic [1:0] op, input logic [31:0] addr);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, addr, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_list_op(op, addr));
    words_sent[op]++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  // result side: random stalls between words
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    list_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = status_e'(m_axis_tdata[ST_W-1:0]);
      got.position    = m_axis_tdata[ST_W +: POS_W];
      got.entry_count = m_axis_tdata[ST_W+POS_W +: CNT_W];
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding: %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status != exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, got.status);
          error_count++;
        end
        if (got.position != exp_res.position) begin
          $error("position: expected %0d, actual %0d", exp_res.position, got.position);
          error_count++;
        end
        if (got.entry_count != exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                 got.entry_count);
          error_count++;
        end
        case (exp_res.status)
          ST_FULL: full_seen++;
          ST_OK:   hits_seen++;
          default: misses_seen++;
        endcase
      end
    end
  end

  task automatic test_empty_table();
    send_word(OP_SEARCH, 32'h0000_0000);
    send_word(OP_DELETE, 32'hFFFF_FFFF);
  endtask

  task automatic test_unused_op();
    send_word(OP_UNUSED, 32'h0000_0000);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_address_extremes();
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_INSERT, 32'h8000_0000);
    send_word(OP_SEARCH, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 32'h0000_0000);
    send_word(OP_DELETE, 32'h0000_0000);
  endtask

  // equal addresses keep arrival order, delete takes the first copy
  task automatic test_duplicates();
    send_word(OP_INSERT, 32'h0000_1234);
    send_word(OP_INSERT, 32'h0000_1234);
    send_word(OP_SEARCH, 32'h0000_1234);
    send_word(OP_DELETE, 32'h0000_1234);
    send_word(OP_DELETE, 32'h5555_AAAA);
  endtask

  task automatic test_full_table();
    while (held_count < LIST_DEPTH)
      send_word(OP_INSERT, $urandom());
    send_word(OP_INSERT, 32'h0000_0001);
    send_word(OP_UNUSED, 32'h0000_0001);
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned ins_weight;
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] addr;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      // alternate filling, draining and mixed phases
      case (phase % 3)
        0:       ins_weight = 70;
        1:       ins_weight = 15;
        default: ins_weight = 40;
      endcase
      foreach (addr_pool[k])
        case ($urandom_range(0, 5))
          0:       addr_pool[k] = 32'h0000_0000;
          1:       addr_pool[k] = 32'hFFFF_FFFF;
          default: addr_pool[k] = $urandom();
        endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)
          op = OP_UNUSED;
        else if (pick < ins_weight)
          op = OP_INSERT;
        else if (pick < ins_weight + (100 - ins_weight) / 3)
          op = OP_SEARCH;
        else
          op = OP_DELETE;
        pick = $urandom_range(0, 9);
        if (pick < 5)
          addr = addr_pool[$urandom_range(0, 5)];
        else if (pick < 8 && held_count > 0)
          addr = held_addr[$urandom_range(0, held_count - 1)] + $urandom_range(0, 2) - 1;
        else
          addr = $urandom();
        send_word(op, addr);
      end
      // hold off until the table has answered everything
      if (phase == RAND_PHASES / 2)
        wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    held_count    = 0;
    no_idle       = 1'b0;
    words_sent    = '{default: 0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_unused_op();
    test_address_extremes();
    test_duplicates();
    test_full_table();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("sent %0d inserts, %0d searches, %0d deletes, %0d unused-op words",
             words_sent[OP_INSERT], words_sent[OP_SEARCH], words_sent[OP_DELETE],
             words_sent[OP_UNUSED]);
    $display("answers: %0d done/found, %0d not found, %0d table full",
             hits_seen, misses_seen, full_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
